// File: src/raster_drainage_path_tracer_assert.svh
// Assertion macros shared by the drainage tracer modules
`ifndef RASTER_DRAINAGE_PATH_TRACER_ASSERT_SVH
`define RASTER_DRAINAGE_PATH_TRACER_ASSERT_SVH
// Implication checked every clock, quiet during reset
`define RDPT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rdpt assertion failed");
// Next-cycle implication checked every clock, quiet during reset
`define RDPT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rdpt assertion failed");
`endif

// File: src/rdpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdpt_pkg
// Shared types, sizes and codes of the drainage path tracer.
// ---------------------------------------------------------------------------
package rdpt_pkg;
   localparam int MaxRows   = 256;
   localparam int MaxCols   = 256;
   localparam int RowW      = $clog2(MaxRows);
   localparam int ColW      = $clog2(MaxCols);
   localparam int AddrW     = RowW + ColW;
   localparam int Cells     = MaxRows * MaxCols;
   localparam int DepthW    = AddrW + 1;
   localparam int CfgW      = 9;
   localparam int CountW    = 17;
   localparam int ElevW     = 32;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TRACE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   localparam logic CFG_ROWS = 1'b0;
   localparam logic CFG_COLS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEARING,
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_CENTER,
      ST_SCAN,
      ST_FOLLOW,
      ST_CHECK,
      ST_READ,
      ST_WIPE,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;   // latch request fields
      logic clear_step;  // clear one mark bit (clearing sweep)
      logic clear_start; // restart the clearing sweep
      logic start_trace; // reset counters, try to mark start
      logic pop;         // pop stack top into current cell
      logic load_center; // capture center elevation
      logic scan_reset;  // restart neighbour walk
      logic scan_step;   // issue read of next neighbour / consume data
      logic follow;      // pass 1 (follow lowest)
      logic do_write;    // load elevation
      logic read_issue;  // read cell for read command
      logic out_load;    // load result register
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic outside;
      logic start_marked;
      logic stack_empty;
      logic scan_last;   // all eight neighbours processed
      logic found;
      logic out_busy;
      cmd_type cmd;
   } stat_type;
endpackage

// File: src/raster_drainage_path_tracer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raster_drainage_path_tracer
// D8 drainage tracer over a stored elevation raster with a mark bitmap.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   tvalid / tready    tdata: cmd, row_index, col_index, elevation
// rsp      out  tvalid / tready    tdata: newly_marked, outside_window,
//                                         is_marked, cell_elevation
// csr      in   csr_we             csr_addr, csr_wdata
// Clear runs a full sweep of the mark memory. A trace reads the center and
// neighbours of each visited cell over the single read port, and walks the
// neighbours a second time when one is no higher than the center.
// After reset a sweep clears the mark memory; no item is taken then.
// The result register holds until taken; the walk pauses only at the result.
module raster_drainage_path_tracer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // cmd, row_index, col_index, elevation, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // newly_marked, outside_window, is_marked,
                                   // cell_elevation, pad
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata
);
   rdpt_pkg::ctrl_type ctrl;
   rdpt_pkg::stat_type stat;
   logic [16:0] newly;
   logic        outside, marked;
   logic [31:0] elev;

   rdpt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .ctrl(ctrl)
   );

   rdpt_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_fields(req_tdata[49:0]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_newly(newly), .rsp_outside(outside), .rsp_marked(marked),
      .rsp_elev(elev),
      .ctrl(ctrl), .stat(stat)
   );

   assign rsp_tdata = {5'b0, elev, marked, outside, newly};
endmodule

// File: src/rdpt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdpt_ctrl
// Sequencer of the tracer: command dispatch and the walk loop.
// ---------------------------------------------------------------------------
`include "raster_drainage_path_tracer_assert.svh"
module rdpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rdpt_pkg::stat_type  stat,
   output rdpt_pkg::ctrl_type  ctrl
);
   rdpt_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdpt_pkg::ST_CLEARING;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rdpt_pkg::ST_CLEARING: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = rdpt_pkg::ST_IDLE;
            end
         end
         rdpt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.take_item = 1'b1;
               state_in       = rdpt_pkg::ST_CHECK;
            end
         end
         rdpt_pkg::ST_CHECK: begin
            priority if (stat.cmd == rdpt_pkg::CMD_CLEAR) begin
               ctrl.clear_start = 1'b1;
               state_in         = rdpt_pkg::ST_WIPE;
            end else if (stat.outside || stat.cmd == rdpt_pkg::CMD_LOAD) begin
               ctrl.do_write = !stat.outside;
               state_in      = rdpt_pkg::ST_RESULT;
            end else if (stat.cmd == rdpt_pkg::CMD_READ) begin
               ctrl.read_issue = 1'b1;
               state_in        = rdpt_pkg::ST_READ;
            end else begin
               ctrl.read_issue = 1'b1;
               state_in        = rdpt_pkg::ST_START;
            end
         end
         rdpt_pkg::ST_WIPE: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = rdpt_pkg::ST_RESULT;
            end
         end
         rdpt_pkg::ST_READ: begin
            ctrl.read_issue = 1'b1;
            state_in        = rdpt_pkg::ST_RESULT;
         end
         rdpt_pkg::ST_START: begin
            ctrl.start_trace = 1'b1;
            state_in = stat.start_marked ? rdpt_pkg::ST_RESULT : rdpt_pkg::ST_POP;
         end
         rdpt_pkg::ST_POP: begin
            if (stat.stack_empty) begin
               state_in = rdpt_pkg::ST_RESULT;
            end else begin
               ctrl.pop = 1'b1;
               state_in = rdpt_pkg::ST_CENTER;
            end
         end
         rdpt_pkg::ST_CENTER: begin
            ctrl.load_center = 1'b1;
            ctrl.scan_reset  = 1'b1;
            state_in         = rdpt_pkg::ST_SCAN;
         end
         rdpt_pkg::ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (stat.scan_last) begin
               ctrl.scan_reset = 1'b1;
               state_in = stat.found ? rdpt_pkg::ST_FOLLOW : rdpt_pkg::ST_POP;
            end
         end
         rdpt_pkg::ST_FOLLOW: begin
            ctrl.scan_step = 1'b1;
            ctrl.follow    = 1'b1;
            if (stat.scan_last) begin
               state_in = rdpt_pkg::ST_POP;
            end
         end
         rdpt_pkg::ST_RESULT: begin
            // keep the read cell on the read port while the result waits
            ctrl.read_issue = 1'b1;
            if (!stat.out_busy) begin
               ctrl.out_load = 1'b1;
               state_in      = rdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdpt_pkg::ST_IDLE;
         end
      endcase
   end

   `RDPT_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == rdpt_pkg::ST_IDLE)
   `RDPT_ASSERT_NEXT(a_take_check, clock, reset, ctrl.take_item, state_ff == rdpt_pkg::ST_CHECK)
   `RDPT_ASSERT_IMP(a_one_out, clock, reset, ctrl.out_load, !stat.out_busy)
endmodule

// File: src/rdpt_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdpt_datapath
// Elevation and mark memories, pending stack, neighbour scan, result reg.
// ---------------------------------------------------------------------------
`include "raster_drainage_path_tracer_assert.svh"
module rdpt_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [rdpt_pkg::CfgW-1:0]          csr_wdata,
   input  logic [rdpt_pkg::AddrW+ rdpt_pkg::ElevW+1:0] req_fields,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rdpt_pkg::CountW-1:0]        rsp_newly,
   output logic                               rsp_outside,
   output logic                               rsp_marked,
   output logic [rdpt_pkg::ElevW-1:0]         rsp_elev,
   input  rdpt_pkg::ctrl_type                 ctrl,
   output rdpt_pkg::stat_type                 stat
);
   localparam int AW = rdpt_pkg::AddrW;
   localparam int RW = rdpt_pkg::RowW;
   localparam int CW = rdpt_pkg::ColW;
   localparam int EW = rdpt_pkg::ElevW;

   // memories
   logic [EW-1:0] elev_mem [rdpt_pkg::Cells];
   logic          mark_mem [rdpt_pkg::Cells];
   logic [AW-1:0] stack_mem [rdpt_pkg::Cells];

   logic [rdpt_pkg::CfgW-1:0] rows_ff, cols_ff;
   rdpt_pkg::cmd_type         cmd_ff;
   logic [RW-1:0]             row_ff;
   logic [CW-1:0]             col_ff;
   logic [EW-1:0]             wval_ff;
   logic                      outside_ff;
   logic [AW:0]               clr_ff;
   logic [rdpt_pkg::DepthW-1:0] depth_ff, depth_in;
   logic [rdpt_pkg::CountW-1:0] count_ff;
   logic [AW-1:0]             cur_ff;
   logic signed [EW-1:0]      here_ff, low_ff;
   logic                      found_ff;
   logic [3:0]                scan_ff;   // neighbour index issued
   logic                      pend_ff;   // a read is in flight
   logic                      pvalid_ff; // issued neighbour was in window
   logic [AW-1:0]             paddr_ff;
   logic [EW-1:0]             erd_ff;
   logic                      mrd_ff;
   logic [AW-1:0]             srd_ff;
   logic                      rsp_valid_ff;
   logic [rdpt_pkg::CountW-1:0] rsp_newly_ff;
   logic                      rsp_out_ff, rsp_mark_ff;
   logic [EW-1:0]             rsp_elev_ff;

   // window check of the request
   logic [RW-1:0] req_row;
   logic [CW-1:0] req_col;
   logic          req_out;
   assign req_row = req_fields[2 +: RW];
   assign req_col = req_fields[2+RW +: CW];
   assign req_out = ({1'b0, req_row} >= rows_ff) || ({1'b0, req_col} >= cols_ff);

   // neighbour address for the scan position, row-major around the center
   logic [RW:0]   nr;
   logic [CW:0]   nc;
   logic          n_ok;
   logic [AW-1:0] n_addr;
   always_comb begin
      logic [1:0] dr, dc;
      unique case (scan_ff[2:0])
         3'd0: begin dr = 2'd0; dc = 2'd0; end
         3'd1: begin dr = 2'd0; dc = 2'd1; end
         3'd2: begin dr = 2'd0; dc = 2'd2; end
         3'd3: begin dr = 2'd1; dc = 2'd0; end
         3'd4: begin dr = 2'd1; dc = 2'd2; end
         3'd5: begin dr = 2'd2; dc = 2'd0; end
         3'd6: begin dr = 2'd2; dc = 2'd1; end
         default: begin dr = 2'd2; dc = 2'd2; end
      endcase
      nr = {1'b0, cur_ff[AW-1 -: RW]} + (RW+1)'(dr) - (RW+1)'(1);
      nc = {1'b0, cur_ff[CW-1:0]} + (CW+1)'(dc) - (CW+1)'(1);
      // past the last row or column of the raster is outside any window
      n_ok = !((dr == 2'd0) && (cur_ff[AW-1 -: RW] == '0))
          && !((dc == 2'd0) && (cur_ff[CW-1:0] == '0))
          && !nr[RW] && !nc[CW]
          && (nr < rows_ff) && (nc < cols_ff) && !scan_ff[3];
      n_addr = {nr[RW-1:0], nc[CW-1:0]};
   end

   logic signed [EW-1:0] e_s;
   logic                 elig;
   assign e_s  = $signed(erd_ff);
   assign elig = pend_ff && pvalid_ff && (e_s <= here_ff);
   logic push_nb;
   assign push_nb = ctrl.follow && elig && (e_s == low_ff) && !mrd_ff;

   // push/mark: the start cell or an eligible neighbour
   logic          push;
   logic [AW-1:0] push_addr;
   assign push      = (ctrl.start_trace && !mrd_ff) || push_nb;
   assign push_addr = ctrl.start_trace ? {row_ff, col_ff} : paddr_ff;

   // stack depth after this cycle; a full stack drops the push
   logic          stack_wr;
   logic [AW-1:0] stack_waddr;
   assign stack_wr    = push && (depth_ff < rdpt_pkg::DepthW'(rdpt_pkg::Cells));
   assign stack_waddr = ctrl.start_trace ? '0 : depth_ff[AW-1:0];
   always_comb begin
      depth_in = depth_ff;
      if (ctrl.start_trace) begin
         depth_in = mrd_ff ? '0 : rdpt_pkg::DepthW'(1);
      end else if (stack_wr) begin
         depth_in = depth_ff + rdpt_pkg::DepthW'(1);
      end else if (ctrl.pop) begin
         depth_in = depth_ff - rdpt_pkg::DepthW'(1);
      end
   end

   // memory address select
   logic [AW-1:0] rd_addr;
   assign rd_addr = (ctrl.read_issue) ? {row_ff, col_ff} :
                    (ctrl.load_center) ? cur_ff : n_addr;

   // memories: one write, registered reads
   always_ff @(posedge clock) begin
      if (ctrl.do_write) begin
         elev_mem[{row_ff, col_ff}] <= wval_ff;
      end
      erd_ff <= elev_mem[rd_addr];
      if (ctrl.clear_step && !clr_ff[AW]) begin
         mark_mem[clr_ff[AW-1:0]] <= 1'b0;
      end else if (push) begin
         mark_mem[push_addr] <= 1'b1;
      end
      // fresh mark bit, bypass a push into the same cell
      mrd_ff <= (push && push_addr == rd_addr) ? 1'b1 : mark_mem[rd_addr];
      if (stack_wr) begin
         stack_mem[stack_waddr] <= push_addr;
      end
      // hold the top of the stack as it stands after this cycle
      srd_ff <= stack_wr ? push_addr : stack_mem[depth_in[AW-1:0] - AW'(1)];
   end

   // configuration and request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= rdpt_pkg::CfgW'(rdpt_pkg::MaxRows);
         cols_ff <= rdpt_pkg::CfgW'(rdpt_pkg::MaxCols);
      end else if (csr_we) begin
         if (csr_addr == rdpt_pkg::CFG_ROWS) rows_ff <= csr_wdata;
         else                                cols_ff <= csr_wdata;
      end
      if (ctrl.take_item) begin
         cmd_ff     <= rdpt_pkg::cmd_type'(req_fields[1:0]);
         row_ff     <= req_row;
         col_ff     <= req_col;
         wval_ff    <= req_fields[2+AW +: EW];
         outside_ff <= req_out;
      end
   end

   // clearing sweep, stack, walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         depth_ff <= '0;
         count_ff <= '0;
      end else begin
         if (ctrl.clear_start) clr_ff <= '0;
         else if (ctrl.clear_step && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
         depth_ff <= depth_in;
         if (ctrl.start_trace) begin
            count_ff <= mrd_ff ? '0 : rdpt_pkg::CountW'(1);
         end else if (push) begin
            count_ff <= count_ff + 1'b1;
         end
      end
      if (ctrl.pop) cur_ff <= srd_ff;
      if (ctrl.scan_reset) begin
         scan_ff <= '0;
         pend_ff <= 1'b0;
      end else if (ctrl.scan_step) begin
         scan_ff   <= scan_ff + (scan_ff[3] ? 4'd0 : 4'd1);
         pend_ff   <= !scan_ff[3];
         pvalid_ff <= n_ok;
         paddr_ff  <= n_addr;
      end
      if (ctrl.load_center) found_ff <= 1'b0;
      else if (!ctrl.follow && elig && (!found_ff || e_s < low_ff)) begin
         found_ff <= 1'b1;
         low_ff   <= e_s;
      end
   end

   // center elevation arrives in the cycle after load_center
   logic center_ld_ff;
   always_ff @(posedge clock) begin
      center_ld_ff <= ctrl.load_center;
      if (center_ld_ff) here_ff <= $signed(erd_ff);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.out_load) begin
         rsp_newly_ff <= (cmd_ff == rdpt_pkg::CMD_TRACE && !outside_ff) ? count_ff : '0;
         rsp_out_ff   <= outside_ff && cmd_ff != rdpt_pkg::CMD_CLEAR;
         rsp_mark_ff  <= (cmd_ff == rdpt_pkg::CMD_READ && !outside_ff) ? mrd_ff : 1'b0;
         rsp_elev_ff  <= (cmd_ff == rdpt_pkg::CMD_READ && !outside_ff) ? erd_ff : '0;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_newly   = rsp_newly_ff;
   assign rsp_outside = rsp_out_ff;
   assign rsp_marked  = rsp_mark_ff;
   assign rsp_elev    = rsp_elev_ff;

   always_comb begin
      stat              = '0;
      stat.clear_done   = clr_ff[AW];
      stat.outside      = outside_ff;
      stat.start_marked = mrd_ff;
      stat.stack_empty  = (depth_ff == '0);
      stat.scan_last    = scan_ff[3] && !pend_ff;
      stat.found        = found_ff || elig;
      stat.out_busy     = rsp_valid_ff && !rsp_tready;
      stat.cmd          = cmd_ff;
   end

   `RDPT_ASSERT_IMP(a_no_push_clear, clock, reset, push, !ctrl.clear_step)
   `RDPT_ASSERT_IMP(a_depth_cap, clock, reset, 1'b1,
      depth_ff <= rdpt_pkg::DepthW'(rdpt_pkg::Cells))
   `RDPT_ASSERT_NEXT(a_start_count, clock, reset, ctrl.start_trace && !mrd_ff,
      count_ff == rdpt_pkg::CountW'(1))
endmodule

// File: dv/raster_drainage_path_tracer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raster_drainage_path_tracer_checker
// Watches the request, response and register ports of the drainage tracer,
// keeps its own raster, mark map and window, predicts each response and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module raster_drainage_path_tracer_checker
   import rdpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   // packed from the top bit down, so newly_marked sits in the low bits
   typedef struct packed {
      logic signed [ElevW-1:0] cell_elevation;
      logic                    is_marked;
      logic                    outside_window;
      logic [CountW-1:0]       newly_marked;
   } answer_type;

   logic signed [ElevW-1:0] height_map [Cells];
   bit                      marked     [Cells];
   int unsigned             walk_stack [Cells];
   int unsigned             rows_reg;
   int unsigned             cols_reg;
   answer_type              answer_q [$];

   function automatic int unsigned win_rows();
      return (rows_reg < MaxRows) ? rows_reg : MaxRows;
   endfunction

   function automatic int unsigned win_cols();
      return (cols_reg < MaxCols) ? cols_reg : MaxCols;
   endfunction

   // Walk downhill from one cell; return the count of cells newly marked
   function automatic int unsigned flood_trace(int unsigned r0, int unsigned c0);
      int unsigned nr, nc, depth, count, idx, r, c, n;
      logic signed [ElevW-1:0] here, low, e;
      bit found;
      int rr, cc;
      nr = win_rows();
      nc = win_cols();
      depth = 0;
      count = 0;
      idx = r0 * MaxCols + c0;
      if (marked[idx]) return 0;
      marked[idx] = 1;
      count++;
      walk_stack[depth++] = idx;
      while (depth > 0) begin
         depth--;
         idx = walk_stack[depth];
         r = idx / MaxCols;
         c = idx % MaxCols;
         here = height_map[idx];
         found = 0;
         low = '0;
         // first find the lowest eligible neighbour, then follow every match
         for (int pass = 0; pass < 2; pass++) begin
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = int'(r) + dr;
                  cc = int'(c) + dc;
                  if (dr == 0 && dc == 0) continue;
                  if (rr < 0 || cc < 0 || rr >= int'(nr) || cc >= int'(nc)) continue;
                  n = rr * MaxCols + cc;
                  e = height_map[n];
                  if (e > here) continue;
                  if (pass == 0) begin
                     if (!found || e < low) begin
                        low = e;
                        found = 1;
                     end
                  end else if (e == low && !marked[n]) begin
                     marked[n] = 1;
                     count++;
                     if (depth < Cells) walk_stack[depth++] = n;
                  end
               end
            end
            if (!found) break;
         end
      end
      return count;
   endfunction

   // Predict on each accepted item, compare each accepted response
   always @(posedge clock) begin
      cmd_type                 cmd;
      int unsigned             r, c, idx;
      logic signed [ElevW-1:0] ev;
      answer_type              want, got;
      bit                      outside;
      if (reset) begin
         foreach (marked[i]) marked[i] = 0;
         rows_reg = MaxRows;
         cols_reg = MaxCols;
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CFG_ROWS) rows_reg = csr_wdata;
            else rows_reg = rows_reg;
            if (csr_addr == CFG_COLS) cols_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            cmd = cmd_type'(req_tdata[1:0]);
            r = req_tdata[9:2];
            c = req_tdata[17:10];
            ev = req_tdata[49:18];
            outside = (r >= win_rows()) || (c >= win_cols());
            idx = r * MaxCols + c;
            want = '0;
            want.outside_window = (cmd != CMD_CLEAR) && outside;
            case (cmd)
               CMD_LOAD: if (!outside) height_map[idx] = ev;
               CMD_TRACE: if (!outside) want.newly_marked = CountW'(flood_trace(r, c));
               CMD_READ: if (!outside) begin
                  want.is_marked = marked[idx];
                  want.cell_elevation = height_map[idx];
               end
               default: foreach (marked[i]) marked[i] = 0;
            endcase
            answer_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[50:0];
            if (answer_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %h", got);
            end else begin
               want = answer_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: marked %0d/%0d outside %b/%b flag %b/%b elev %0d/%0d",
                              want.newly_marked, got.newly_marked,
                              want.outside_window, got.outside_window,
                              want.is_marked, got.is_marked,
                              want.cell_elevation, got.cell_elevation);
               end
            end
         end
      end
      pending = answer_q.size();
   end
endmodule

// File: dv/tb_raster_drainage_path_tracer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_raster_drainage_path_tracer
// Drives loads, traces, reads and clears over a series of window settings,
// each window fully loaded first, with random idling on both sides and one
// long response hold-off; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_raster_drainage_path_tracer;
   import rdpt_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;  // cmd, row_index, col_index, elevation, pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;  // newly_marked, outside_window, is_marked,
                            // cell_elevation, pad
   logic        csr_we;
   logic        csr_addr;
   logic [8:0]  csr_wdata;
   int          fail_count;
   int          pending;
   bit          send_gaps;
   bit          rsp_stalls;
   int unsigned idle_pct;
   int unsigned idle_phase;
   int          hold_cycles;
   int          clears_left;
   int unsigned wr, wc;

   raster_drainage_path_tracer dut (.*);

   raster_drainage_path_tracer_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Response side: long hold-off first, else random stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = !(rsp_stalls && $urandom_range(0, 99) < idle_pct);
         end
      end
   end

   // Offer one item, return at the falling edge after it is taken
   task automatic send_item(cmd_type cmd, int unsigned r, int unsigned c,
                            logic [31:0] ev);
      if (send_gaps) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tdata = {6'b0, ev, c[7:0], r[7:0], cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic addr, int unsigned val);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = val[8:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Small values make ties and flats; sometimes full range or extremes
   function automatic logic [31:0] pick_elev();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 75) return $urandom_range(0, 6) - 3;
      if (p < 90) return $urandom;
      if (p < 95) return 32'h8000_0000;
      return 32'h7fff_ffff;
   endfunction

   // Set the window, then load every cell in it so no unloaded cell is read
   task automatic set_window(int unsigned rows, int unsigned cols);
      drain();
      write_reg(CFG_ROWS, rows);
      write_reg(CFG_COLS, cols);
      wr = (rows < MaxRows) ? rows : MaxRows;
      wc = (cols < MaxCols) ? cols : MaxCols;
      for (int unsigned r = 0; r < wr; r++)
         for (int unsigned c = 0; c < wc; c++)
            send_item(CMD_LOAD, r, c, pick_elev());
   endtask

   task automatic random_items(int n);
      int unsigned r, c, p;
      cmd_type cmd;
      for (int i = 0; i < n; i++) begin
         if (wr > 0 && wc > 0 && $urandom_range(0, 99) < 75) begin
            r = $urandom_range(0, wr - 1);
            c = $urandom_range(0, wc - 1);
         end else begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
         end
         p = $urandom_range(0, 199);
         if (p == 0 && clears_left > 0) begin
            cmd = CMD_CLEAR;
            clears_left--;
         end else if (p < 60) cmd = CMD_TRACE;
         else if (p < 120) cmd = CMD_READ;
         else cmd = CMD_LOAD;
         send_item(cmd, r, c, pick_elev());
      end
   endtask

   // Step through the phases: none, sender idle, receiver stalls, both
   task automatic set_idling();
      int unsigned m;
      m = idle_phase % 4;
      idle_phase++;
      send_gaps = (m == 1 || m == 3);
      rsp_stalls = (m == 2 || m == 3);
      idle_pct = (m == 3) ? 16 : 45;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CFG_ROWS;
      csr_wdata = '0;
      send_gaps = 0;
      rsp_stalls = 0;
      idle_pct = 45;
      idle_phase = 0;
      hold_cycles = 0;
      clears_left = 4;
      wr = 0;
      wc = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, corners, repeated trace, outside cells, clear
      set_window(4, 5);
      send_item(CMD_LOAD, 0, 0, 32'h8000_0000);
      send_item(CMD_LOAD, 3, 4, 32'h7fff_ffff);
      send_item(CMD_TRACE, 3, 4, '0);
      send_item(CMD_TRACE, 3, 4, '0);
      send_item(CMD_READ, 0, 0, '0);
      send_item(CMD_READ, 3, 4, '0);
      send_item(CMD_TRACE, 1, 2, '0);
      send_item(CMD_LOAD, 255, 255, 32'hffff_ffff);
      send_item(CMD_TRACE, 4, 0, '0);
      send_item(CMD_READ, 0, 5, '0);
      send_item(CMD_READ, 255, 255, '0);
      send_item(CMD_CLEAR, 255, 255, 32'h5555_aaaa);
      send_item(CMD_READ, 3, 4, '0);
      send_item(CMD_TRACE, 0, 0, '0);

      // Long response hold-off while items keep coming
      drain();
      hold_cycles = 3000;
      random_items(30);

      // Phases over several windows, extremes included
      set_idling();
      set_window(9, 13);
      random_items(100);
      set_idling();
      set_window(1, 1);
      random_items(40);
      set_idling();
      set_window(511, 1);
      random_items(100);
      set_idling();
      set_window(1, 511);
      random_items(100);
      set_idling();
      set_window(0, 9);
      random_items(40);
      set_idling();
      set_window(6, 0);
      random_items(40);
      set_idling();
      set_window(2, 40);
      random_items(80);
      set_idling();
      set_window(8, 8);
      random_items(100);
      set_idling();
      set_window(5, 7);
      random_items(80);
      send_gaps = 0;
      rsp_stalls = 0;
      set_window(3, 3);
      random_items(40);

      drain();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
